// ===== src/pvs_pkg.sv =====
`default_nettype none

package pvs_pkg;

	// Field widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned POS_W    = 5;
	localparam int unsigned DIM_W    = 6;
	localparam int unsigned CFG_IDX_W = 2;

	// Accumulator holds six neighbors plus twice the center
	localparam int unsigned ACC_W = SAMPLE_W + 4;

	// Action codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 2'd2;

	// Reset value of each dimension register
	localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

	// Stencil taps, issued to the store one per cycle
	localparam logic [2:0] TAP_CENTER = 3'd0;
	localparam logic [2:0] TAP_XM     = 3'd1;
	localparam logic [2:0] TAP_XP     = 3'd2;
	localparam logic [2:0] TAP_YM     = 3'd3;
	localparam logic [2:0] TAP_YP     = 3'd4;
	localparam logic [2:0] TAP_ZM     = 3'd5;
	localparam logic [2:0] TAP_ZP     = 3'd6;

	typedef struct packed {
		logic                       action;
		logic [POS_W-1:0]           x_pos;
		logic [POS_W-1:0]           y_pos;
		logic [POS_W-1:0]           z_pos;
		logic signed [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smoothed_value;
		logic                       coord_error;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

endpackage

`default_nettype wire

// ===== src/pvs_stream_if.sv =====
`default_nettype none

interface pvs_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/pvs_ram.sv =====
`default_nettype none

module pvs_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 32768,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port: write or registered read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/periodic_volume_smoother_unit.sv =====
`default_nettype none

// Periodic volume smoother. Keeps a MAX_WIDTH x MAX_HEIGHT x MAX_DEPTH volume of
// signed Q1.15 samples in one single-port RAM. A write transaction (action 0)
// stores its sample at (x,y,z) on acceptance and returns nothing; writes outside
// the dimensions in use are dropped. A read transaction (action 1) returns
// (six face neighbors + 2*center) >>> 3, with neighbors wrapping at the
// dimensions in use. The seven taps are fetched one per cycle from the RAM, so
// a read passes through ST_READ (the seven RAM reads), ST_DRAIN (the RAM read
// latency) and ST_OUT, where the result is loaded once the result register is
// free, and the next transaction is taken back in ST_IDLE; a read outside the
// dimensions goes from ST_IDLE straight to ST_OUT and returns 0 with coord_error set.
// The result register lets the next transaction in while a result waits.
// Dimension registers of 0 act as 1 and values above the maximum act as the
// maximum. A voxel must be written before any read touches it; the RAM is not
// cleared.
module periodic_volume_smoother_unit
	import pvs_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = 32,
	parameter int unsigned MAX_HEIGHT = 32,
	parameter int unsigned MAX_DEPTH  = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_wdata,
	pvs_stream_if.sink                in_ch,
	pvs_stream_if.source              out_ch
);

	localparam int unsigned CELLS = MAX_WIDTH * MAX_HEIGHT * MAX_DEPTH;
	localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int unsigned DIM_TOP = (1 << DIM_W) - 1;
	localparam logic [DIM_W-1:0] W_LIM = DIM_W'((MAX_WIDTH  > DIM_TOP) ? DIM_TOP : MAX_WIDTH);
	localparam logic [DIM_W-1:0] H_LIM = DIM_W'((MAX_HEIGHT > DIM_TOP) ? DIM_TOP : MAX_HEIGHT);
	localparam logic [DIM_W-1:0] D_LIM = DIM_W'((MAX_DEPTH  > DIM_TOP) ? DIM_TOP : MAX_DEPTH);

	in_item_t in_item;
	assign in_item = in_ch.data;

	logic [DIM_W-1:0] width_q, height_q, depth_q;
	logic [DIM_W-1:0] w_eff, h_eff, d_eff;
	state_t           state_q;
	logic [2:0]       tap_q;
	logic [DIM_W-1:0] x_q, y_q, z_q;
	logic             rd_s1, center_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic             err_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic             in_fire, inside_in, out_free;
	logic [DIM_W-1:0] sel_x, sel_y, sel_z;
	logic [DIM_W-1:0] xm, xp, ym, yp, zm, zp;
	logic [31:0]      addr_wide;
	logic             mem_en, mem_we;
	logic [SAMPLE_W-1:0] mem_rdata;
	logic signed [ACC_W-1:0] tap_val;

	// Clamp dimension registers to the usable range
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
			input logic [DIM_W-1:0] lim);
		logic [DIM_W-1:0] v;
		if (r == '0) begin
			v = DIM_W'(1);
		end else if (r > lim) begin
			v = lim;
		end else begin
			v = r;
		end
		return v;
	endfunction

	assign w_eff = eff_dim(width_q,  W_LIM);
	assign h_eff = eff_dim(height_q, H_LIM);
	assign d_eff = eff_dim(depth_q,  D_LIM);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
			depth_q  <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_wdata;
				CFG_HEIGHT: height_q <= cfg_wdata;
				CFG_DEPTH:  depth_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign inside_in   = ({1'b0, in_item.x_pos} < w_eff) && ({1'b0, in_item.y_pos} < h_eff)
		&& ({1'b0, in_item.z_pos} < d_eff);
	assign out_free    = !out_valid_q || out_ch.ready;

	// Wrapped neighbor coordinates of the held voxel
	assign xm = (x_q == '0) ? w_eff - 1'b1 : x_q - 1'b1;
	assign xp = (x_q + 1'b1 >= w_eff) ? '0 : x_q + 1'b1;
	assign ym = (y_q == '0) ? h_eff - 1'b1 : y_q - 1'b1;
	assign yp = (y_q + 1'b1 >= h_eff) ? '0 : y_q + 1'b1;
	assign zm = (z_q == '0) ? d_eff - 1'b1 : z_q - 1'b1;
	assign zp = (z_q + 1'b1 >= d_eff) ? '0 : z_q + 1'b1;

	// Select the coordinate for the RAM port
	always_comb begin
		sel_x = x_q;
		sel_y = y_q;
		sel_z = z_q;
		if (state_q == ST_IDLE) begin
			sel_x = {1'b0, in_item.x_pos};
			sel_y = {1'b0, in_item.y_pos};
			sel_z = {1'b0, in_item.z_pos};
		end else begin
			unique case (tap_q)
				TAP_CENTER: ;
				TAP_XM: sel_x = xm;
				TAP_XP: sel_x = xp;
				TAP_YM: sel_y = ym;
				TAP_YP: sel_y = yp;
				TAP_ZM: sel_z = zm;
				TAP_ZP: sel_z = zp;
				default: ;
			endcase
		end
	end

	assign addr_wide = (32'(sel_z) * 32'(MAX_HEIGHT) + 32'(sel_y)) * 32'(MAX_WIDTH)
		+ 32'(sel_x);
	assign mem_we = in_fire && (in_item.action == ACT_WRITE) && inside_in;
	assign mem_en = mem_we || (state_q == ST_READ);

	pvs_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(CELLS)
	) u_store (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (addr_wide[AW-1:0]),
		.wdata (in_item.sample),
		.rdata (mem_rdata)
	);

	// Returned tap, doubled for the center
	assign tap_val = center_s1
		? (ACC_W'(signed'(mem_rdata)) <<< 1)
		: ACC_W'(signed'(mem_rdata));

	// Sequence the taps and hand off the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_q       <= TAP_CENTER;
			rd_s1       <= 1'b0;
			center_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1     <= (state_q == ST_READ);
			center_s1 <= (state_q == ST_READ) && (tap_q == TAP_CENTER);
			// Load a new result or drop the one just taken
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && (in_item.action == ACT_READ)) begin
						tap_q   <= TAP_CENTER;
						state_q <= inside_in ? ST_READ : ST_OUT;
					end
				end
				ST_READ: begin
					tap_q <= tap_q + 3'd1;
					if (tap_q == TAP_ZP) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the read coordinate and accumulate taps
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q   <= {1'b0, in_item.x_pos};
			y_q   <= {1'b0, in_item.y_pos};
			z_q   <= {1'b0, in_item.z_pos};
			err_q <= !inside_in;
			acc_q <= '0;
		end else if (rd_s1) begin
			acc_q <= acc_q + tap_val;
		end
		if ((state_q == ST_OUT) && out_free) begin
			out_q.smoothed_value <= acc_q[SAMPLE_W+2:3];
			out_q.coord_error    <= err_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

endmodule

`default_nettype wire

// ===== tb/periodic_volume_smoother_unit_tb.sv =====
`default_nettype none

module periodic_volume_smoother_unit_tb;
	import pvs_pkg::*;

	localparam int unsigned VOL_SIDE      = 32;
	localparam int unsigned VOL_VOXELS    = VOL_SIDE * VOL_SIDE * VOL_SIDE;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned LONG_STALL    = 300;
	localparam int unsigned CYCLE_LIMIT   = 500000;
	localparam int unsigned PHASE_ITEMS   = 92;
	localparam int unsigned NUM_PHASES    = 9;
	localparam int unsigned MAX_GAP       = 24;

	typedef enum logic {
		ROW_OP,
		ROW_DIMS
	} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		in_item_t         op;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [DIM_W-1:0] d;
		bit               known;
		out_item_t        want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_wdata;

	pvs_stream_if #(.T(in_item_t))  in_ch ();
	pvs_stream_if #(.T(out_item_t)) out_ch ();

	periodic_volume_smoother_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Shadow of the volume and the dimension registers
	logic signed [SAMPLE_W-1:0] voxel_mem [VOL_VOXELS];
	bit                         voxel_written [VOL_VOXELS];
	logic [DIM_W-1:0]           dim_w = DIM_RESET;
	logic [DIM_W-1:0]           dim_h = DIM_RESET;
	logic [DIM_W-1:0]           dim_d = DIM_RESET;

	out_item_t   pending_smoothed [$];
	out_item_t   oldest_smoothed;
	stim_row_t   stim_rows [$];
	int unsigned mismatch_count = 0;
	int unsigned items_sent     = 0;
	int unsigned cycle_count    = 0;
	int unsigned sender_idle_pct   = 26;
	int unsigned receiver_idle_pct = 84;
	int          last_x = 0;
	int          last_y = 0;
	int          last_z = 0;
	bit          stall_ask  = 1'b0;
	bit          stall_seen = 1'b0;

	function automatic int eff_dim(logic [DIM_W-1:0] r);
		if (r == 0) return 1;
		if (r > VOL_SIDE) return VOL_SIDE;
		return int'(r);
	endfunction

	function automatic int unsigned voxel_addr(int x, int y, int z);
		return (z * VOL_SIDE + y) * VOL_SIDE + x;
	endfunction

	function automatic bit in_bounds(int x, int y, int z);
		return x < eff_dim(dim_w) && y < eff_dim(dim_h) && z < eff_dim(dim_d);
	endfunction

	function automatic int wrap_prev(int v, int n);
		return (v == 0) ? n - 1 : v - 1;
	endfunction

	function automatic int wrap_next(int v, int n);
		return (v + 1 >= n) ? 0 : v + 1;
	endfunction

	function automatic int voxel_at(int x, int y, int z);
		return int'(voxel_mem[voxel_addr(x, y, z)]);
	endfunction

	// Seven-point periodic stencil: (six faces + 2*center) >>> 3
	function automatic out_item_t smooth_at(int x, int y, int z);
		out_item_t res;
		int w, h, d, sum, scaled;
		w = eff_dim(dim_w);
		h = eff_dim(dim_h);
		d = eff_dim(dim_d);
		res = '0;
		if (!in_bounds(x, y, z)) begin
			res.coord_error = 1'b1;
			return res;
		end
		sum = 2 * voxel_at(x, y, z)
			+ voxel_at(wrap_prev(x, w), y, z) + voxel_at(wrap_next(x, w), y, z)
			+ voxel_at(x, wrap_prev(y, h), z) + voxel_at(x, wrap_next(y, h), z)
			+ voxel_at(x, y, wrap_prev(z, d)) + voxel_at(x, y, wrap_next(z, d));
		scaled = sum >>> 3;
		res.smoothed_value = scaled[SAMPLE_W-1:0];
		return res;
	endfunction

	function automatic in_item_t make_op(logic act, int x, int y, int z,
			logic signed [SAMPLE_W-1:0] sample);
		in_item_t op;
		op.action = act;
		op.x_pos  = x[POS_W-1:0];
		op.y_pos  = y[POS_W-1:0];
		op.z_pos  = z[POS_W-1:0];
		op.sample = sample;
		return op;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic void add_op(logic act, int x, int y, int z,
			logic signed [SAMPLE_W-1:0] sample, bit known,
			logic signed [SAMPLE_W-1:0] want_value, logic want_error);
		stim_row_t row;
		row = '{kind: ROW_OP, op: make_op(act, x, y, z, sample), w: '0, h: '0, d: '0,
			known: known, want: '{smoothed_value: want_value, coord_error: want_error}};
		stim_rows.push_back(row);
	endfunction

	function automatic void add_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
			logic [DIM_W-1:0] d);
		stim_row_t row;
		row = '{kind: ROW_DIMS, op: '0, w: w, h: h, d: d, known: 1'b0, want: '0};
		stim_rows.push_back(row);
	endfunction

	// Update the shadow volume and queue the expected result of a transaction
	function automatic void record_accepted(in_item_t op, bit known, out_item_t want);
		int unsigned a;
		a = voxel_addr(op.x_pos, op.y_pos, op.z_pos);
		items_sent++;
		if (op.action == ACT_WRITE) begin
			if (in_bounds(op.x_pos, op.y_pos, op.z_pos)) begin
				voxel_mem[a]     = op.sample;
				voxel_written[a] = 1'b1;
			end
		end else begin
			pending_smoothed.push_back(known ? want : smooth_at(op.x_pos, op.y_pos, op.z_pos));
		end
	endfunction

	// Pick a coordinate outside the dimensions in use, if there is one
	function automatic bit pick_outside(output int x, output int y, output int z);
		int lim [3];
		int axis;
		lim[0] = eff_dim(dim_w);
		lim[1] = eff_dim(dim_h);
		lim[2] = eff_dim(dim_d);
		x = $urandom_range(VOL_SIDE - 1);
		y = $urandom_range(VOL_SIDE - 1);
		z = $urandom_range(VOL_SIDE - 1);
		if (lim[0] == VOL_SIDE && lim[1] == VOL_SIDE && lim[2] == VOL_SIDE) return 1'b0;
		do axis = $urandom_range(2); while (lim[axis] == VOL_SIDE);
		case (axis)
			0: x = $urandom_range(VOL_SIDE - 1, lim[0]);
			1: y = $urandom_range(VOL_SIDE - 1, lim[1]);
			default: z = $urandom_range(VOL_SIDE - 1, lim[2]);
		endcase
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		mismatch_count++;
	endtask

	// Offer one transaction after a random gap and hold it until accepted
	task automatic offer_op(in_item_t op, bit known, out_item_t want);
		int unsigned gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= op;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		record_accepted(op, known, want);
	endtask

	task automatic ensure_written(int x, int y, int z);
		if (!voxel_written[voxel_addr(x, y, z)])
			offer_op(make_op(ACT_WRITE, x, y, z, rand_sample()), 1'b0, '0);
	endtask

	// Fill any unwritten stencil tap first, then issue the read
	task automatic read_smoothed(int x, int y, int z);
		int w, h, d;
		w = eff_dim(dim_w);
		h = eff_dim(dim_h);
		d = eff_dim(dim_d);
		if (in_bounds(x, y, z)) begin
			ensure_written(x, y, z);
			ensure_written(wrap_prev(x, w), y, z);
			ensure_written(wrap_next(x, w), y, z);
			ensure_written(x, wrap_prev(y, h), z);
			ensure_written(x, wrap_next(y, h), z);
			ensure_written(x, y, wrap_prev(z, d));
			ensure_written(x, y, wrap_next(z, d));
		end
		offer_op(make_op(ACT_READ, x, y, z, rand_sample()), 1'b0, '0);
		last_x = x;
		last_y = y;
		last_z = z;
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic drain_results(int unsigned extra);
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_smoothed.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic set_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
			logic [DIM_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_index <= CFG_DEPTH;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		dim_w = w;
		dim_h = h;
		dim_d = d;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("periodic_volume_smoother_unit_tb NOT OK");
		$finish;
	end

	// Receiver: random backpressure, plus a long hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_ask != stall_seen) begin
				stall_seen = stall_ask;
				out_ch.ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
			end
			out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_smoothed.size() == 0) begin
				report_mismatch("unexpected result", out_ch.data.smoothed_value, 0);
			end else begin
				oldest_smoothed = pending_smoothed.pop_front();
				if (out_ch.data.smoothed_value !== oldest_smoothed.smoothed_value)
					report_mismatch("smoothed_value", out_ch.data.smoothed_value,
						oldest_smoothed.smoothed_value);
				if (out_ch.data.coord_error !== oldest_smoothed.coord_error)
					report_mismatch("coord_error", out_ch.data.coord_error,
						oldest_smoothed.coord_error);
			end
		end
	end

	initial begin
		int          pick, x, y, z, w, h, d;
		int unsigned phase_start;
		bit          mid_done;
		logic [DIM_W-1:0] pw, ph, pd;

		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= CFG_WIDTH;
		cfg_wdata   <= '0;
		in_ch.valid <= 1'b0;
		in_ch.data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Wrap at the top corner, all taps at the positive extreme
		add_op(ACT_WRITE, 31, 31, 31, 16'sh7FFF, 1'b0, 0, 1'b0);
		add_op(ACT_WRITE, 30, 31, 31, 16'sh7FFF, 1'b0, 0, 1'b0);
		add_op(ACT_WRITE, 0, 31, 31, 16'sh7FFF, 1'b0, 0, 1'b0);
		add_op(ACT_WRITE, 31, 30, 31, 16'sh7FFF, 1'b0, 0, 1'b0);
		add_op(ACT_WRITE, 31, 0, 31, 16'sh7FFF, 1'b0, 0, 1'b0);
		add_op(ACT_WRITE, 31, 31, 30, 16'sh7FFF, 1'b0, 0, 1'b0);
		add_op(ACT_WRITE, 31, 31, 0, 16'sh7FFF, 1'b0, 0, 1'b0);
		add_op(ACT_READ, 31, 31, 31, 16'sh0000, 1'b1, 16'sh7FFF, 1'b0);
		// Single-voxel volume: every neighbor is the center itself
		add_dims(6'd1, 6'd1, 6'd1);
		add_op(ACT_WRITE, 0, 0, 0, 16'sh8000, 1'b0, 0, 1'b0);
		add_op(ACT_READ, 0, 0, 0, 16'sh0000, 1'b1, 16'sh8000, 1'b0);
		add_op(ACT_WRITE, 0, 0, 0, 16'sh7FFF, 1'b0, 0, 1'b0);
		add_op(ACT_READ, 0, 0, 0, 16'shFFFF, 1'b1, 16'sh7FFF, 1'b0);
		add_op(ACT_WRITE, 0, 0, 0, 16'shFFFF, 1'b0, 0, 1'b0);
		add_op(ACT_READ, 0, 0, 0, 16'sh1234, 1'b1, 16'shFFFF, 1'b0);
		// Write outside the volume is dropped
		add_op(ACT_WRITE, 3, 0, 0, 16'sh0064, 1'b0, 0, 1'b0);
		add_op(ACT_READ, 0, 0, 0, 16'sh0000, 1'b1, 16'shFFFF, 1'b0);
		// Reads outside the volume flag an error
		add_op(ACT_READ, 31, 31, 31, 16'sh7FFF, 1'b1, 16'sh0000, 1'b1);
		add_op(ACT_READ, 1, 0, 0, 16'sh8000, 1'b1, 16'sh0000, 1'b1);
		// Zero acts as one
		add_dims(6'd0, 6'd0, 6'd0);
		add_op(ACT_READ, 0, 0, 0, 16'sh0000, 1'b1, 16'shFFFF, 1'b0);
		add_op(ACT_READ, 0, 1, 0, 16'sh0000, 1'b1, 16'sh0000, 1'b1);
		// Oversized acts as the maximum, store content survives
		add_dims(6'd63, 6'd63, 6'd63);
		add_op(ACT_READ, 31, 31, 31, 16'sh0000, 1'b1, 16'sh7FFF, 1'b0);
		// Width of two: both x neighbors are the same voxel
		add_dims(6'd2, 6'd1, 6'd1);
		add_op(ACT_WRITE, 1, 0, 0, 16'sh0008, 1'b0, 0, 1'b0);
		add_op(ACT_READ, 0, 0, 0, 16'sh0000, 1'b0, 0, 1'b0);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_DIMS) begin
				drain_results(SETTLE_CYCLES);
				set_dims(stim_rows[i].w, stim_rows[i].h, stim_rows[i].d);
			end else begin
				offer_op(stim_rows[i].op, stim_rows[i].known, stim_rows[i].want);
			end
		end

		// Random phases, each under its own dimensions
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: {pw, ph, pd} = {6'd4, 6'd4, 6'd4};
				1: {pw, ph, pd} = {6'd32, 6'd1, 6'd1};
				2: {pw, ph, pd} = {6'd1, 6'd32, 6'd1};
				3: {pw, ph, pd} = {6'd1, 6'd1, 6'd32};
				4: {pw, ph, pd} = {6'd5, 6'd3, 6'd7};
				5: {pw, ph, pd} = {6'd32, 6'd32, 6'd32};
				6: {pw, ph, pd} = {6'd63, 6'd0, 6'd17};
				default: begin
					pw = DIM_W'($urandom_range(63));
					ph = DIM_W'($urandom_range(63));
					pd = DIM_W'($urandom_range(63));
				end
			endcase
			drain_results(SETTLE_CYCLES);
			set_dims(pw, ph, pd);
			w = eff_dim(dim_w);
			h = eff_dim(dim_h);
			d = eff_dim(dim_d);
			phase_start = items_sent;
			mid_done = 1'b0;
			while (items_sent < phase_start + PHASE_ITEMS) begin
				// Sender busy / receiver slow, then swapped, then no idling
				if (items_sent < 300) begin
					sender_idle_pct   = 26;
					receiver_idle_pct = 84;
				end else if (items_sent < 580) begin
					sender_idle_pct   = 84;
					receiver_idle_pct = 26;
				end else begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
				end
				// Halfway: long receiver hold-off or a full sender pause
				if (!mid_done && items_sent >= phase_start + PHASE_ITEMS / 2) begin
					mid_done = 1'b1;
					if (p % 2 == 1) stall_ask <= ~stall_ask;
					else drain_results(0);
				end
				pick = $urandom_range(99);
				if (pick < 62) begin
					if ($urandom_range(1)) begin
						x = (last_x % w + $urandom_range(2) + w - 1) % w;
						y = (last_y % h + $urandom_range(2) + h - 1) % h;
						z = (last_z % d + $urandom_range(2) + d - 1) % d;
					end else begin
						x = $urandom_range(w - 1);
						y = $urandom_range(h - 1);
						z = $urandom_range(d - 1);
					end
					read_smoothed(x, y, z);
				end else if (pick < 82) begin
					x = $urandom_range(w - 1);
					y = $urandom_range(h - 1);
					z = $urandom_range(d - 1);
					offer_op(make_op(ACT_WRITE, x, y, z, rand_sample()), 1'b0, '0);
				end else if (pick < 89) begin
					void'(pick_outside(x, y, z));
					offer_op(make_op(ACT_WRITE, x, y, z, rand_sample()), 1'b0, '0);
				end else if (pick < 95) begin
					void'(pick_outside(x, y, z));
					read_smoothed(x, y, z);
				end else begin
					x = $urandom_range(VOL_SIDE - 1);
					y = $urandom_range(VOL_SIDE - 1);
					z = $urandom_range(VOL_SIDE - 1);
					if ($urandom_range(1)) read_smoothed(x, y, z);
					else offer_op(make_op(ACT_WRITE, x, y, z, rand_sample()), 1'b0, '0);
				end
			end
		end

		drain_results(SETTLE_CYCLES);
		if (mismatch_count == 0)
			$display("periodic_volume_smoother_unit_tb OK");
		else
			$display("periodic_volume_smoother_unit_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
